### rtl/core/csl_pkg.sv
// Shared types, token codes and character class helpers for the C subset lexer.
`default_nettype none

package csl_pkg;

    // Token classes carried on the result tuser.
    localparam logic [2:0] CLS_PUNCT   = 3'd0;
    localparam logic [2:0] CLS_KEYWORD = 3'd1;
    localparam logic [2:0] CLS_IDENT   = 3'd2;
    localparam logic [2:0] CLS_NUMBER  = 3'd3;
    localparam logic [2:0] CLS_END     = 3'd4;
    localparam logic [2:0] CLS_UNKNOWN = 3'd5;

    // Kind of token held back while the next byte decides it.
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PUNCT = 2'd1;
    localparam logic [1:0] PEND_IDENT = 2'd2;
    localparam logic [1:0] PEND_NUM   = 2'd3;

    localparam logic [62:0] NUM_MAX = {63{1'b1}};

    localparam int KW_COUNT = 6;

    // Keywords packed first byte highest, as the identifier prefix is built.
    localparam logic [47:0] KW_PACKED [KW_COUNT] = '{
        48'h72_65_74_75_72_6E,   // return
        48'h00_00_00_00_69_66,   // if
        48'h00_00_74_68_65_6E,   // then
        48'h00_00_65_6C_73_65,   // else
        48'h00_00_00_66_6F_72,   // for
        48'h00_77_68_69_6C_65    // while
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd2, 3'd4, 3'd4, 3'd3, 3'd5};

    typedef struct packed {
        logic [2:0]  cls;
        logic [31:0] start;
        logic [15:0] len;
        logic [62:0] value;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [2:0]  kw;
        logic        last;
    } token_t;

    function automatic logic is_name_lead(input logic [7:0] c);
        return (c == 8'h5F) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic is_opstart(input logic [7:0] c);
        return (c == 8'h3D) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h21);
    endfunction

endpackage

`default_nettype wire

### rtl/core/c_subset_lexer_core.sv
// Top level of the C subset lexer: byte classifier, token state and result queue.
//
// Channel   Dir   tdata                 tuser             tlast
// s_axis    in    char_byte             kind              -
// m_axis    out   token fields          token_class       last_result
//
// Each accepted byte is decoded against the token state in the cycle it is taken,
// and its zero, one or two tokens enter a four-word result queue at that edge.
// A byte is taken every cycle while the queue has two free slots, so one byte per
// cycle is sustained whenever the sink drains about one token per cycle.
// The first token can leave in the cycle after its byte is accepted.
// Reset (aresetn low, synchronous) empties the queue and clears the token state.
// A stalled sink only fills the queue; s_axis_tready falls once fewer than two
// slots remain.
`default_nettype none

module c_subset_lexer_core
    import csl_pkg::*;
#(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,    // [7:0] char_byte
    input  wire logic [0:0]   s_axis_tuser,    // [0] kind

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] start_offset, [47:32] token_length, [110:48] number_value,
    // [118:111] first_char, [126:119] second_char, [129:127] keyword_index, rest zero
    output logic [135:0]      m_axis_tdata,
    output logic [2:0]        m_axis_tuser,    // [2:0] token_class
    output logic              m_axis_tlast     // last_result
);

    localparam int QDEPTH = 4;
    localparam int QBITS  = $clog2(QDEPTH);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Token state.
    logic [1:0]             pend_reg,   pend_next;
    logic [7:0]             pchar_reg,  pchar_next;
    logic [OFFSET_BITS-1:0] start_reg,  start_next;
    logic [LENGTH_BITS-1:0] count_reg,  count_next;
    logic [47:0]            prefix_reg, prefix_next;
    logic [62:0]            accum_reg,  accum_next;
    logic [OFFSET_BITS-1:0] pos_reg,    pos_next;
    logic                   halted_reg, halted_next;

    // Result queue.
    token_t                 queue_reg [QDEPTH];
    logic [QBITS-1:0]       head_reg, tail_reg;
    logic [QBITS:0]         cnt_reg;

    logic        accept, pop, is_end;
    logic [7:0]  c;
    logic        res_a_valid, res_b_valid;
    token_t      res_a, res_b, flush_res, slot0;
    logic        kw_hit;
    logic [2:0]  kw_idx;
    logic        taken;
    logic [66:0] acc_sum;
    logic [62:0] acc_digit;

    assign c      = s_axis_tdata;
    assign is_end = s_axis_tuser[0] || (c == 8'd0);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (cnt_reg <= (QBITS+1)'(QDEPTH - 2));

    // Keyword match on the held identifier; a saturated length never matches.
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = 3'd0;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (count_reg == LENGTH_BITS'(KW_LEN[i]) && prefix_reg == KW_PACKED[i]) begin
                kw_hit = 1'b1;
                kw_idx = 3'(i);
            end
        end
    end

    // The token that a flush of the held state would emit.
    always_comb begin
        flush_res       = '0;
        flush_res.start = 32'(start_reg);
        flush_res.len   = 16'(count_reg);
        case (pend_reg)
            PEND_PUNCT: begin
                flush_res.cls = CLS_PUNCT;
                flush_res.len = 16'd1;
                flush_res.c1  = pchar_reg;
            end
            PEND_IDENT: begin
                flush_res.cls = kw_hit ? CLS_KEYWORD : CLS_IDENT;
                flush_res.kw  = kw_hit ? kw_idx : 3'd0;
            end
            PEND_NUM: begin
                flush_res.cls   = CLS_NUMBER;
                flush_res.value = accum_reg;
            end
            default: begin
                flush_res.cls = CLS_PUNCT;
            end
        endcase
    end

    // Decimal accumulate: saturate once ten times the value plus the digit passes
    // the largest value.
    assign acc_digit = 63'(c - 8'h30);
    assign acc_sum   = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0} + 67'(acc_digit);

    always_comb begin
        pend_next   = pend_reg;
        pchar_next  = pchar_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        prefix_next = prefix_reg;
        accum_next  = accum_reg;
        pos_next    = pos_reg;
        halted_next = halted_reg;
        res_a_valid = 1'b0;
        res_b_valid = 1'b0;
        res_a       = flush_res;
        res_b       = '0;
        taken       = 1'b0;

        if (accept) begin
            if (is_end) begin
                // Flush, then the end token at the current offset; all state clears.
                res_a_valid  = (pend_reg != PEND_NONE);
                res_b_valid  = 1'b1;
                res_b.cls    = CLS_END;
                res_b.start  = 32'(pos_reg);
                pend_next    = PEND_NONE;
                pchar_next   = 8'd0;
                start_next   = '0;
                count_next   = '0;
                prefix_next  = '0;
                accum_next   = '0;
                pos_next     = '0;
                halted_next  = 1'b0;
            end else begin
                if (!halted_reg) begin
                    case (pend_reg)
                        PEND_PUNCT: begin
                            taken = (c == 8'h3D);
                        end
                        PEND_IDENT: begin
                            taken = is_name_lead(c) || is_digit(c);
                            if (taken) begin
                                if (count_reg < LENGTH_BITS'(6)) begin
                                    prefix_next = {prefix_reg[39:0], c};
                                end
                                if (count_reg != LEN_MAX) begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        PEND_NUM: begin
                            taken = is_digit(c);
                            if (taken) begin
                                accum_next = (acc_sum > 67'(NUM_MAX)) ? NUM_MAX : acc_sum[62:0];
                                if (count_reg != LEN_MAX) begin
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        default: begin
                            taken = 1'b0;
                        end
                    endcase

                    if (pend_reg == PEND_PUNCT && taken) begin
                        // Two-character operator completes.
                        res_a_valid = 1'b1;
                        res_a.len   = 16'd2;
                        res_a.c2    = c;
                        pend_next   = PEND_NONE;
                        pchar_next  = 8'd0;
                    end else if (pend_reg != PEND_NONE && !taken) begin
                        res_a_valid = 1'b1;
                        pend_next   = PEND_NONE;
                        pchar_next  = 8'd0;
                        count_next  = '0;
                        prefix_next = '0;
                        accum_next  = '0;
                    end

                    if (!taken && !is_space(c)) begin
                        start_next = pos_reg;
                        count_next = LENGTH_BITS'(1);
                        res_b.start = 32'(pos_reg);
                        res_b.len   = 16'd1;
                        res_b.c1    = c;
                        if (is_opstart(c)) begin
                            pend_next  = PEND_PUNCT;
                            pchar_next = c;
                        end else if (is_name_lead(c)) begin
                            pend_next   = PEND_IDENT;
                            prefix_next = 48'(c);
                        end else if (is_punct(c)) begin
                            res_b_valid = 1'b1;
                            res_b.cls   = CLS_PUNCT;
                            count_next  = '0;
                        end else if (is_digit(c)) begin
                            pend_next  = PEND_NUM;
                            accum_next = acc_digit;
                        end else begin
                            res_b_valid = 1'b1;
                            res_b.cls   = CLS_UNKNOWN;
                            count_next  = '0;
                            halted_next = 1'b1;
                        end
                    end
                end
                pos_next = pos_reg + 1'b1;
            end
        end

        res_a.last = !res_b_valid;
        res_b.last = 1'b1;
        slot0      = res_a_valid ? res_a : res_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= PEND_NONE;
            pchar_reg  <= 8'd0;
            start_reg  <= '0;
            count_reg  <= '0;
            prefix_reg <= '0;
            accum_reg  <= '0;
            pos_reg    <= '0;
            halted_reg <= 1'b0;
        end else begin
            pend_reg   <= pend_next;
            pchar_reg  <= pchar_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            prefix_reg <= prefix_next;
            accum_reg  <= accum_next;
            pos_reg    <= pos_next;
            halted_reg <= halted_next;
        end
    end

    // Result queue: up to two words pushed per byte, one popped per cycle.
    always_ff @(posedge aclk) begin
        if (res_a_valid || res_b_valid) begin
            queue_reg[tail_reg] <= slot0;
        end
        if (res_a_valid && res_b_valid) begin
            queue_reg[tail_reg + 1'b1] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            tail_reg <= tail_reg + QBITS'({1'b0, res_a_valid} + {1'b0, res_b_valid});
            if (pop) begin
                head_reg <= head_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QBITS+1)'({1'b0, res_a_valid} + {1'b0, res_b_valid})
                       - (QBITS+1)'(pop);
        end
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tuser  = queue_reg[head_reg].cls;
    assign m_axis_tlast  = queue_reg[head_reg].last;
    assign m_axis_tdata  = {6'd0,
                            queue_reg[head_reg].kw,
                            queue_reg[head_reg].c2,
                            queue_reg[head_reg].c1,
                            queue_reg[head_reg].value,
                            queue_reg[head_reg].len,
                            queue_reg[head_reg].start};

    // The queue never holds more words than it has slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QBITS+1)'(QDEPTH))
        else $error("result queue overflow");

    // An end-of-input word returns the token state to its reset values.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_end |=> pend_reg == PEND_NONE && pos_reg == '0 && !halted_reg)
        else $error("state not cleared after end of input");

    // After an unknown byte nothing is held until end of input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> pend_reg == PEND_NONE)
        else $error("token held while halted");

    // The end token is always the final word of its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == CLS_END |-> m_axis_tlast)
        else $error("end token without last flag");

endmodule

`default_nettype wire
